>>> design/mugc_pkg.sv
// Package for the union-find graph counter: widths, constants, state type.
// Used by mst_unique_graph_count_union_find and mugc_modmul.
`timescale 1ns / 1ps
`default_nettype none
package mugc_pkg;
   localparam int MaxNodesDefault = 4096;
   localparam logic [29:0] Modulus = 30'd998244353;
   localparam int CsrAddrWidth = 3;
   localparam logic [CsrAddrWidth-1:0] AddrWeightLimit = 3'd0;
   localparam logic [CsrAddrWidth-1:0] AddrNodeCount = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_FIND_A, ST_WAIT_A, ST_FIND_B, ST_WAIT_B,
      ST_LINK, ST_POW, ST_MUL, ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [29:0] a;
      logic [29:0] b;
   } mul_req_type;
endpackage
`default_nettype wire

>>> design/mst_unique_graph_count_union_find.sv
// Union-find graph counter: each accepted word is one tree edge, and one result
// word with the running product follows after the roots are found by walking
// parent links in memory, and the factor is raised by square-and-multiply on a
// bit-serial modular multiplier (up to two multiplies per exponent bit of
// sizeA*sizeB-1). A first edge first clears the active entries (node_count,
// capped at MaxNodes), one per cycle. Depends on mugc_pkg, mugc_ram and
// mugc_modmul.
`timescale 1ns / 1ps
`default_nettype none
module mst_unique_graph_count_union_find
   import mugc_pkg::*;
#(
   parameter int MaxNodes = MaxNodesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // end_a[12:0], end_b[25:13], edge_weight[55:26]
   input  wire logic [55:0] req_tdata,
   // first_edge
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // running_product[29:0], merged[30], weight_over[31]
   output logic [31:0]      rsp_tdata,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready
);
   localparam int Aw = $clog2(MaxNodes);
   localparam int Sw = Aw + 1;
   localparam int Ew = 2 * Sw;

   state_type state_ff, state_in;
   logic [29:0] limit_ff, limit_in;
   logic [12:0] ncount_ff, ncount_in;
   logic [Sw-1:0] nact;
   logic [12:0] ea_ff, eb_ff, ea_in, eb_in;
   logic [29:0] w_ff, w_in;
   logic first_ff, first_in;
   logic [Sw-1:0] clr_ff, clr_in;
   logic [Aw-1:0] cur_ff, cur_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [Sw-1:0] sa_ff, sa_in;
   logic [29:0] ma_ff, ma_in;
   logic [29:0] prod_ff, prod_in, base_ff, base_in, acc_ff, acc_in;
   logic [Ew-1:0] exp_ff, exp_in;
   logic [1:0] phase_ff, phase_in;
   logic merged_ff, merged_in, over_ff, over_in, out_v_ff, out_v_in;

   logic wr_en;
   logic [Aw-1:0] wr_addr, rd_addr;
   logic [Aw+Sw+29:0] wr_data, rd_data;
   logic [Aw-1:0] rd_par;
   logic [Sw-1:0] rd_size;
   logic [29:0] rd_max;
   mul_req_type mreq;
   logic mbusy;
   logic [29:0] mprod;
   logic [29:0] m_sel;
   logic [30:0] base_sum;
   logic [Sw-1:0] sb;
   logic [Ew-1:0] pairs;
   logic end_ok;

   mugc_ram #(.Width(Aw + Sw + 30), .Depth(MaxNodes)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
   mugc_modmul u_mul (.clock, .reset, .req(mreq), .busy(mbusy), .prod(mprod));

   assign rd_par = rd_data[Aw+Sw+29 -: Aw];
   assign rd_size = rd_data[Sw+29 -: Sw];
   assign rd_max = rd_data[29:0];
   assign nact = (32'(ncount_ff) > 32'(MaxNodes)) ? Sw'(MaxNodes) : Sw'(ncount_ff);
   assign sb = rd_size;
   assign pairs = Ew'(sa_ff) * Ew'(sb);

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr)
         AddrWeightLimit: csr_prdata = {2'b0, limit_ff};
         AddrNodeCount:   csr_prdata = {19'b0, ncount_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {over_ff, merged_ff, prod_ff};

   always_comb begin
      state_in = state_ff;
      limit_in = limit_ff;
      ncount_in = ncount_ff;
      ea_in = ea_ff; eb_in = eb_ff; w_in = w_ff; first_in = first_ff;
      clr_in = clr_ff; cur_in = cur_ff; ra_in = ra_ff; rb_in = rb_ff;
      sa_in = sa_ff; ma_in = ma_ff; prod_in = prod_ff; base_in = base_ff;
      acc_in = acc_ff; exp_in = exp_ff; phase_in = phase_ff;
      merged_in = merged_ff; over_in = over_ff; out_v_in = out_v_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = cur_ff;
      mreq = '0;
      m_sel = '0;
      base_sum = '0;
      end_ok = (ea_ff != 13'd0) && (32'(ea_ff) <= 32'(nact))
            && (eb_ff != 13'd0) && (32'(eb_ff) <= 32'(nact));
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == AddrWeightLimit) limit_in = csr_pwdata[29:0];
         if (csr_paddr == AddrNodeCount) ncount_in = csr_pwdata[12:0];
      end
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               ea_in = req_tdata[12:0];
               eb_in = req_tdata[25:13];
               w_in = req_tdata[55:26];
               first_in = req_tuser;
               merged_in = 1'b0; over_in = 1'b0;
               clr_in = '0;
               state_in = (req_tuser && nact != '0) ? ST_CLEAR : ST_FIND_A;
               if (req_tuser) prod_in = 30'd1;
            end
         end
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[Aw-1:0];
            wr_data = {clr_ff[Aw-1:0], Sw'(1), 30'd0};
            clr_in = clr_ff + Sw'(1);
            if (clr_ff + Sw'(1) >= nact) state_in = ST_FIND_A;
         end
         ST_FIND_A: begin
            if (!end_ok) begin
               out_v_in = 1'b1; state_in = ST_IDLE;
            end else begin
               cur_in = Aw'(ea_ff - 13'd1); state_in = ST_WAIT_A;
            end
         end
         ST_WAIT_A: begin
            rd_addr = cur_ff;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd1) begin
               phase_in = 2'd0;
               if (rd_par == cur_ff) begin
                  ra_in = cur_ff; sa_in = rd_size; ma_in = rd_max;
                  cur_in = Aw'(eb_ff - 13'd1); state_in = ST_FIND_B;
               end else begin
                  cur_in = rd_par;
               end
            end
         end
         ST_FIND_B: begin
            rd_addr = cur_ff;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd1) begin
               phase_in = 2'd0;
               if (rd_par == cur_ff) begin
                  rb_in = cur_ff; state_in = ST_WAIT_B;
               end else begin
                  cur_in = rd_par;
               end
            end
         end
         ST_WAIT_B: begin
            rd_addr = rb_ff;
            if (ra_ff == rb_ff) begin
               out_v_in = 1'b1; state_in = ST_IDLE;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            rd_addr = rb_ff;
            m_sel = (rd_max > ma_ff) ? rd_max : ma_ff;
            if (w_ff > m_sel) m_sel = w_ff;
            wr_en = 1'b1;
            wr_addr = (sb > sa_ff) ? rb_ff : ra_ff;
            wr_data = {wr_addr, Sw'(sa_ff + sb), m_sel};
            ra_in = (sb > sa_ff) ? ra_ff : rb_ff;
            rb_in = wr_addr;
            merged_in = 1'b1;
            exp_in = (pairs == '0) ? '0 : pairs - Ew'(1);
            base_sum = {1'b0, 30'(limit_ff - m_sel)} + 31'd1;
            base_in = (base_sum >= {1'b0, Modulus}) ? 30'(base_sum - {1'b0, Modulus})
                                                   : base_sum[29:0];
            acc_in = 30'd1;
            phase_in = 2'd0;
            if (m_sel > limit_ff) begin
               over_in = 1'b1; prod_in = '0; out_v_in = 1'b1; state_in = ST_DONE;
            end else begin
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            if (!mbusy) begin
               unique case (phase_ff)
                  2'd0: begin
                     if (exp_ff == '0) begin
                        mreq = '{start: 1'b1, a: prod_ff, b: acc_ff};
                        state_in = ST_MUL;
                     end else if (exp_ff[0]) begin
                        mreq = '{start: 1'b1, a: acc_ff, b: base_ff};
                        phase_in = 2'd1;
                     end else begin
                        mreq = '{start: 1'b1, a: base_ff, b: base_ff};
                        phase_in = 2'd2;
                     end
                  end
                  2'd1: begin
                     acc_in = mprod;
                     mreq = '{start: 1'b1, a: base_ff, b: base_ff};
                     phase_in = 2'd2;
                  end
                  default: begin
                     base_in = mprod;
                     exp_in = exp_ff >> 1;
                     phase_in = 2'd0;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (!mbusy) begin
               prod_in = mprod; out_v_in = 1'b1; state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            wr_en = 1'b1;
            wr_addr = ra_ff;
            wr_data = {rb_ff, Sw'(1), 30'd0};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= 30'd1;
         ncount_ff <= 13'd2;
         prod_ff <= 30'd1;
         out_v_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         ncount_ff <= ncount_in;
         prod_ff <= prod_in;
         out_v_ff <= out_v_in;
         phase_ff <= phase_in;
      end
      ea_ff <= ea_in; eb_ff <= eb_in; w_ff <= w_in; first_ff <= first_in;
      clr_ff <= clr_in; cur_ff <= cur_in; ra_ff <= ra_in; rb_ff <= rb_in;
      sa_ff <= sa_in; ma_ff <= ma_in; base_ff <= base_in; acc_ff <= acc_in;
      exp_ff <= exp_in; merged_ff <= merged_in; over_ff <= over_in;
   end
endmodule
`default_nettype wire

>>> design/mugc_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mugc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> design/mugc_modmul.sv
// Sequential modular multiplier: one bit of the multiplier per cycle.
// Uses mugc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mugc_modmul
   import mugc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output logic             busy,
   output logic [29:0]      prod
);
   logic [29:0] acc_ff, acc_in, a_ff, a_in;
   logic [29:0] b_ff, b_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [30:0] dbl, dsum;
   logic [29:0] dred, sred;

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      dbl = {acc_ff, 1'b0};
      dred = (dbl >= {1'b0, Modulus}) ? 30'(dbl - {1'b0, Modulus}) : dbl[29:0];
      dsum = {1'b0, dred} + {1'b0, a_ff};
      sred = (dsum >= {1'b0, Modulus}) ? 30'(dsum - {1'b0, Modulus}) : dsum[29:0];
      if (req.start) begin
         acc_in = '0;
         a_in = (req.a >= Modulus) ? 30'(req.a - Modulus) : req.a;
         b_in = req.b;
         cnt_in = 5'd29;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[29] ? sred : dred;
         b_in = {b_ff[28:0], 1'b0};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

>>> verif/mst_unique_graph_count_union_find_tb.sv
// Testbench for the union-find graph counter: drives tree edges on the request
// stream, predicts each result word in a behavioral model and checks it.
// Depends on mugc_pkg and mst_unique_graph_count_union_find.
`timescale 1ns / 1ps
module mst_unique_graph_count_union_find_tb
   import mugc_pkg::*;
;

   localparam int NodeLimit = 4096;
   localparam logic [63:0] Prime = 64'd998244353;

   typedef struct packed {
      logic        over;
      logic        merged;
      logic [29:0] product;
   } count_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   int errors = 0;
   int hold_off = 0;
   count_word_type pending_counts[$];

   logic [12:0] up_link[NodeLimit];
   logic [12:0] comp_size[NodeLimit];
   logic [29:0] comp_max[NodeLimit];
   logic [29:0] graph_product;
   logic [29:0] limit_reg;
   logic [12:0] nodes_reg;

   mst_unique_graph_count_union_find u_dut (.*);

   always #4 clock = ~clock;

   function automatic int active_count();
      return nodes_reg > NodeLimit ? NodeLimit : int'(nodes_reg);
   endfunction

   function automatic int find_root(int idx);
      int up;
      for (int s = 0; s < NodeLimit; s++) begin
         up = up_link[idx];
         if (up >= NodeLimit || up == idx) return idx;
         idx = up;
      end
      return idx;
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] expo);
      logic [63:0] acc;
      acc = 1;
      base = base % Prime;
      while (expo != 0) begin
         if (expo[0]) acc = acc * base % Prime;
         base = base * base % Prime;
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic count_word_type count_edge(bit first, int ea, int eb,
                                                 logic [29:0] w);
      count_word_type res;
      int n, ra, rb, keep, drop;
      logic [29:0] m;
      logic [63:0] pairs, factor;
      n = active_count();
      res = '0;
      if (first) begin
         for (int i = 0; i < n; i++) begin
            up_link[i] = i;
            comp_size[i] = 1;
            comp_max[i] = 0;
         end
         graph_product = 1;
      end
      if (ea >= 1 && ea <= n && eb >= 1 && eb <= n) begin
         ra = find_root(ea - 1);
         rb = find_root(eb - 1);
         if (ra != rb) begin
            m = comp_max[ra];
            if (comp_max[rb] > m) m = comp_max[rb];
            if (w > m) m = w;
            if (comp_size[rb] > comp_size[ra]) begin
               keep = rb;
               drop = ra;
            end else begin
               keep = ra;
               drop = rb;
            end
            pairs = 64'(comp_size[ra]) * 64'(comp_size[rb]);
            up_link[drop] = keep;
            comp_size[keep] = comp_size[ra] + comp_size[rb];
            comp_max[keep] = m;
            if (m > limit_reg) begin
               res.over = 1;
               factor = 0;
            end else begin
               factor = pow_mod(64'(limit_reg - m) + 1, pairs == 0 ? 0 : pairs - 1);
            end
            graph_product = 30'(64'(graph_product) * factor % Prime);
            res.merged = 1;
         end
      end
      res.product = graph_product;
      return res;
   endfunction

   task automatic send_edge(bit first, int ea, int eb, logic [29:0] w);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= {w, 13'(eb), 13'(ea)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_counts.push_back(count_edge(first, ea, eb, w));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrAddrWidth-1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == AddrWeightLimit) limit_reg = value[29:0];
      else if (addr == AddrNodeCount) nodes_reg = value[12:0];
      @(posedge clock);
   endtask

   // A random tree on nodes 1..n with non-decreasing weights (modulo 2**30), plus some noise.
   task automatic send_tree(int n, int noise);
      int order[$];
      int j, k;
      logic [29:0] w;
      for (int i = 1; i <= n; i++) order.push_back(i);
      order.shuffle();
      w = $urandom_range(0, 3) == 0 ? 30'($urandom_range(0, 1000))
                                    : 30'($urandom_range(0, 30'h3FFF_0000));
      send_edge(1, order[0], order[1], w);
      for (int i = 2; i < n; i++) begin
         j = $urandom_range(0, i - 1);
         w = w + 30'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1 << 14));
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, 8191);
            send_edge(0, k, $urandom_range(0, 8191), 30'($urandom));
         end
         if (noise > 0 && $urandom_range(0, 15) == 0)
            send_edge(0, order[j], order[$urandom_range(0, i - 1)], w);
         send_edge(0, order[i], order[j], w);
      end
   endtask

   task automatic test_directed();
      write_csr(AddrWeightLimit, 32'd1);
      write_csr(AddrNodeCount, 32'd2);
      send_edge(1, 1, 2, 30'd1);
      send_edge(0, 2, 1, 30'd1);
      send_edge(0, 0, 1, 30'd1);
      send_edge(1, 2, 2, 30'd0);
      send_edge(0, 1, 2, 30'd2);
      send_edge(0, 8191, 3, 30'h3FFF_FFFF);
      wait_drained();
      write_csr(AddrWeightLimit, 32'h3FFF_FFFF);
      write_csr(AddrNodeCount, 32'd5);
      send_edge(1, 1, 2, 30'd0);
      send_edge(0, 3, 4, 30'd7);
      send_edge(0, 1, 3, 30'd100);
      send_edge(0, 5, 1, 30'h3FFF_FFFF);
      send_edge(0, 6, 1, 30'd5);
      send_edge(0, 4, 2, 30'h3FFF_FFFF);
      send_edge(1, 5, 4, 30'h2AAA_AAAA);
      send_edge(0, 4, 3, 30'h1555_5555);
      wait_drained();
      write_csr(AddrNodeCount, 32'h1FFF);
      write_csr(AddrWeightLimit, 32'd1000);
      send_edge(1, 4096, 1, 30'd999);
      send_edge(0, 4097, 1, 30'd10);
      send_edge(0, 2, 4096, 30'd1000);
      send_edge(0, 3, 1, 30'd1001);
      wait_drained();
   endtask

   task automatic test_big_tree();
      write_csr(AddrWeightLimit, 32'h3FFF_FFFF);
      write_csr(AddrNodeCount, 32'd4096);
      send_tree(40, 0);
      wait_drained();
   endtask

   task automatic test_random_trees();
      int n;
      for (int t = 0; t < 65; t++) begin
         n = $urandom_range(2, 14);
         write_csr(AddrNodeCount, 32'(n));
         write_csr(AddrWeightLimit, $urandom_range(0, 1)
                   ? 32'($urandom_range(1, 30'h3FFF_FFFF)) : 32'($urandom_range(1, 20000)));
         send_tree(n, 1);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      write_csr(AddrNodeCount, 32'd12);
      write_csr(AddrWeightLimit, 32'h3FFF_FFFF);
      hold_off = 3000;
      send_tree(12, 0);
      wait_drained();
   endtask

   always @(posedge clock) begin
      count_word_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = count_word_type'(rsp_tdata);
         if (pending_counts.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_counts.pop_front();
            if (got.product !== want.product) begin
               $error("running_product expected %0d actual %0d", want.product, got.product);
               errors++;
            end
            if (got.merged !== want.merged) begin
               $error("merged expected %0d actual %0d", want.merged, got.merged);
               errors++;
            end
            if (got.over !== want.over) begin
               $error("weight_over expected %0d actual %0d", want.over, got.over);
               errors++;
            end
         end
      end
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            stall = hold_off;
            hold_off = 0;
         end else begin
            stall = $urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 5);
         end
         rsp_tready <= stall == 0;
         @(posedge clock);
         if (stall > 1) repeat (stall - 1) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      graph_product = 1;
      limit_reg = 1;
      nodes_reg = 2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_big_tree();
      test_backpressure();
      test_random_trees();
      wait_drained();
      if (errors == 0 && pending_counts.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> sim.f
design/mugc_pkg.sv
design/mugc_ram.sv
design/mugc_modmul.sv
design/mst_unique_graph_count_union_find.sv
verif/mst_unique_graph_count_union_find_tb.sv
